>>> hw/rtl/dnsenc_pkg.sv
// ----------------------------------------------------------------------------
// DNS name encoder package
// Shared constants and the types used between the controller and the datapath.
// ----------------------------------------------------------------------------
package dnsenc_pkg;

    localparam int MAX_LABEL   = 63;
    localparam int LABEL_DEPTH = 63;
    localparam int LEN_W       = 6;
    localparam int ADDR_W      = 6;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_SINGLE,
        ACT_FLUSH
    } dnsenc_act_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } dnsenc_state_t;

    typedef struct packed {
        logic        in_valid;
        logic        out_free;
        dnsenc_act_t act;
        logic        last_byte;
    } dnsenc_status_t;

    typedef struct packed {
        logic in_ready;
        logic take;
        logic send_byte;
    } dnsenc_cmd_t;

endpackage

>>> hw/rtl/dnsenc_stream_if.sv
// ----------------------------------------------------------------------------
// DNS name encoder stream interfaces
// Valid/ready channels for the character stream and the wire byte stream.
// ----------------------------------------------------------------------------
interface dnsenc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_name;

    modport source (output valid, output ch, output end_of_name, input ready);
    modport sink (input valid, input ch, input end_of_name, output ready);
endinterface

interface dnsenc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       append_zero;
    logic       error;
    logic       last;

    modport source (output valid, output out_byte, output append_zero,
                    output error, output last, input ready);
    modport sink (input valid, input out_byte, input append_zero,
                  input error, input last, output ready);
endinterface

>>> hw/rtl/dns_name_wire_encoder.sv
// ----------------------------------------------------------------------------
// DNS name wire encoder
// Turns a dotted name, one character per beat, into DNS wire format bytes.
// ----------------------------------------------------------------------------
// A character or end beat that produces at most one result is taken when the
// output register is free, and a new beat can be taken every cycle while the
// output register drains. A beat that closes a label of n bytes loads the
// length byte in the cycle it is taken, then one label byte per cycle, while
// the output register drains, from the label RAM read port; no character
// beat is taken until the last label byte is in the output register.
module dns_name_wire_encoder import dnsenc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    dnsenc_char_if.sink   chars,
    dnsenc_byte_if.source wire_bytes
);

    dnsenc_status_t status;
    dnsenc_cmd_t    cmd;

    dnsenc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    dnsenc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .wire_bytes (wire_bytes),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

>>> hw/rtl/dnsenc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module dnsenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dnsenc_ctrl.sv
// ----------------------------------------------------------------------------
// DNS name encoder controller
// Decides when a character beat is taken and steps through a label flush.
// ----------------------------------------------------------------------------
module dnsenc_ctrl import dnsenc_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  dnsenc_status_t status,
    output dnsenc_cmd_t    cmd
);

    dnsenc_state_t state_reg;
    dnsenc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.in_ready  = 1'b0;
        cmd.take      = 1'b0;
        cmd.send_byte = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = status.out_free;
                cmd.take     = status.out_free && status.in_valid;
                if (cmd.take && status.act == ACT_FLUSH)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                cmd.send_byte = status.out_free;
                if (status.out_free && status.last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/dnsenc_datapath.sv
// ----------------------------------------------------------------------------
// DNS name encoder datapath
// Label buffer, name state flags, flush index and the output register.
// ----------------------------------------------------------------------------
module dnsenc_datapath import dnsenc_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    dnsenc_char_if.sink    chars,
    dnsenc_byte_if.source  wire_bytes,
    input  dnsenc_cmd_t    cmd,
    output dnsenc_status_t status
);

    logic [LEN_W-1:0]  len_reg;
    logic              at_start_reg;
    logic              skip_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              final_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_az_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    dnsenc_act_t       act;
    logic              single_err;
    logic              out_free;
    logic              last_byte;
    logic [LEN_W-1:0]  idx_inc;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    always_comb
    begin
        act        = ACT_NONE;
        single_err = 1'b0;
        if (chars.end_of_name)
        begin
            if (!skip_reg)
            begin
                act = (len_reg != '0) ? ACT_FLUSH : ACT_SINGLE;
            end
        end
        else if (!skip_reg)
        begin
            if (chars.ch == DOT_CHAR)
            begin
                act        = (len_reg != '0) ? ACT_FLUSH : ACT_SINGLE;
                single_err = !at_start_reg;
            end
            else if (len_reg >= LEN_W'(MAX_LABEL))
            begin
                act        = ACT_SINGLE;
                single_err = 1'b1;
            end
            else
            begin
                act = ACT_STORE;
            end
        end
    end

    assign out_free  = !out_valid_reg || wire_bytes.ready;
    assign idx_inc   = LEN_W'(idx_reg + 1'b1);
    assign last_byte = (idx_inc == len_reg);

    assign status.in_valid  = chars.valid;
    assign status.out_free  = out_free;
    assign status.act       = act;
    assign status.last_byte = last_byte;

    assign ram_we    = cmd.take && act == ACT_STORE;
    assign ram_re    = (cmd.take && act == ACT_FLUSH) || (cmd.send_byte && !last_byte);
    assign ram_raddr = cmd.send_byte ? idx_inc : '0;

    dnsenc_ram #(
        .WIDTH (8),
        .DEPTH (LABEL_DEPTH)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg),
        .wdata (chars.ch),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            at_start_reg  <= 1'b1;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (chars.end_of_name)
                begin
                    skip_reg     <= 1'b0;
                    at_start_reg <= 1'b1;
                    if (act != ACT_FLUSH)
                    begin
                        len_reg <= '0;
                    end
                end
                else if (!skip_reg)
                begin
                    at_start_reg <= 1'b0;
                    if (act == ACT_SINGLE)
                    begin
                        skip_reg <= 1'b1;
                    end
                    if (act == ACT_STORE)
                    begin
                        len_reg <= LEN_W'(len_reg + 1'b1);
                    end
                end
            end
            if (cmd.send_byte && last_byte)
            begin
                len_reg <= '0;
            end

            if ((cmd.take && (act == ACT_SINGLE || act == ACT_FLUSH)) || cmd.send_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wire_bytes.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && act == ACT_FLUSH)
        begin
            idx_reg      <= '0;
            final_reg    <= chars.end_of_name;
            out_byte_reg <= 8'(len_reg);
            out_az_reg   <= 1'b0;
            out_err_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.take && act == ACT_SINGLE)
        begin
            out_byte_reg <= '0;
            out_az_reg   <= 1'b0;
            out_err_reg  <= single_err;
            out_last_reg <= 1'b1;
        end
        else if (cmd.send_byte)
        begin
            idx_reg      <= ADDR_W'(idx_inc);
            out_byte_reg <= ram_rdata;
            out_az_reg   <= final_reg && last_byte;
            out_err_reg  <= 1'b0;
            out_last_reg <= final_reg && last_byte;
        end
    end

    assign chars.ready            = cmd.in_ready;
    assign wire_bytes.valid       = out_valid_reg;
    assign wire_bytes.out_byte    = out_byte_reg;
    assign wire_bytes.append_zero = out_az_reg;
    assign wire_bytes.error       = out_err_reg;
    assign wire_bytes.last        = out_last_reg;

endmodule
